/* hdl/spq_pkg.sv */
// shared types and constants for the severity priority queue
package spq_pkg;

   localparam int DEPTH_DEFAULT = 32;

   localparam int SEV_W   = 6;
   localparam int AGE_W   = 8;
   localparam int POS_W   = 5;
   localparam int TOTAL_W = 6;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_LIST   = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_ENTRY    = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_PLACE,
      ST_LIST
   } state_type;

   typedef struct packed {
      logic [SEV_W-1:0] sev;
      logic [AGE_W-1:0] age;
   } entry_type;

   typedef struct packed {
      op_type           op;
      logic [SEV_W-1:0] sev;
      logic [AGE_W-1:0] age;
   } cmd_type;

endpackage

/* hdl/spq_front.sv */
// front end: takes request items, decodes them and holds them in a two-entry queue
module spq_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [spq_pkg::SEV_W-1:0]   req_severity,
   input  logic [spq_pkg::AGE_W-1:0]   req_age,
   output logic                        cmd_valid,
   output spq_pkg::cmd_type            cmd,
   input  logic                        cmd_pop
);

   spq_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push;
   spq_pkg::cmd_type new_cmd;

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid & req_ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op  = spq_pkg::op_type'(req_kind);
      new_cmd.sev = req_severity;
      new_cmd.age = req_age;
      wr_ptr_in   = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in   = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in     = fill_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* hdl/spq_engine.sv */
// back end: sorted entry memory, insert shifting, listing and the result register
module spq_engine #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   input  spq_pkg::cmd_type              cmd,
   output logic                          cmd_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [spq_pkg::POS_W-1:0]     rsp_position,
   output logic [spq_pkg::SEV_W-1:0]     rsp_out_severity,
   output logic [spq_pkg::AGE_W-1:0]     rsp_out_age,
   output logic [spq_pkg::TOTAL_W-1:0]   rsp_entry_total,
   output logic                          rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

   spq_pkg::entry_type mem [DEPTH];
   spq_pkg::entry_type rd_data_ff;
   spq_pkg::entry_type wr_data;
   logic               rd_en, wr_en;
   logic [CW-1:0]      rd_sel, wr_sel;
   logic [AW-1:0]      rd_addr, wr_addr;

   spq_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [spq_pkg::SEV_W-1:0] sev_ff, sev_in;
   logic [spq_pkg::AGE_W-1:0] age_ff, age_in;

   logic [CW-1:0]      count_inc, count_dec, slot_m1, slot_m2, idx_inc;
   logic [CW+spq_pkg::TOTAL_W-1:0] total_now_wide, total_inc_wide;
   logic [CW+spq_pkg::POS_W-1:0]   pos_wide;

   logic                           rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type            rsp_status_ff, ld_status;
   logic [spq_pkg::POS_W-1:0]      rsp_position_ff, ld_position;
   logic [spq_pkg::SEV_W-1:0]      rsp_sev_ff, ld_sev;
   logic [spq_pkg::AGE_W-1:0]      rsp_age_ff, ld_age;
   logic [spq_pkg::TOTAL_W-1:0]    rsp_total_ff, ld_total;
   logic                           rsp_last_ff, ld_last;
   logic                           out_load, out_free;

   assign count_inc = count_ff + 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign slot_m1   = slot_ff - 1'b1;
   assign slot_m2   = slot_ff - CW'(2);
   assign idx_inc   = idx_ff + 1'b1;

   assign total_now_wide = {{spq_pkg::TOTAL_W{1'b0}}, count_ff};
   assign total_inc_wide = {{spq_pkg::TOTAL_W{1'b0}}, count_inc};
   assign pos_wide       = {{spq_pkg::POS_W{1'b0}}, idx_ff};

   assign rd_addr  = rd_sel[AW-1:0];
   assign wr_addr  = wr_sel[AW-1:0];
   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      slot_in     = slot_ff;
      idx_in      = idx_ff;
      sev_in      = sev_ff;
      age_in      = age_ff;
      cmd_pop     = 1'b0;
      rd_en       = 1'b0;
      rd_sel      = '0;
      wr_en       = 1'b0;
      wr_sel      = slot_ff;
      wr_data     = rd_data_ff;
      out_load    = 1'b0;
      ld_status   = spq_pkg::STATUS_ACCEPTED;
      ld_position = '0;
      ld_sev      = '0;
      ld_age      = '0;
      ld_total    = total_now_wide[spq_pkg::TOTAL_W-1:0];
      ld_last     = 1'b1;

      case (state_ff)
         spq_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == spq_pkg::OP_INSERT) begin
                  if (count_ff == COUNT_FULL) begin
                     if (out_free) begin
                        cmd_pop   = 1'b1;
                        out_load  = 1'b1;
                        ld_status = spq_pkg::STATUS_FULL;
                     end
                  end else begin
                     cmd_pop = 1'b1;
                     sev_in  = cmd.sev;
                     age_in  = cmd.age;
                     slot_in = count_ff;
                     if (count_ff == '0) begin
                        state_in = spq_pkg::ST_PLACE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_sel   = count_dec;
                        state_in = spq_pkg::ST_CMP;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     if (out_free) begin
                        cmd_pop   = 1'b1;
                        out_load  = 1'b1;
                        ld_status = spq_pkg::STATUS_EMPTY;
                     end
                  end else begin
                     cmd_pop  = 1'b1;
                     idx_in   = '0;
                     rd_en    = 1'b1;
                     rd_sel   = '0;
                     state_in = spq_pkg::ST_LIST;
                  end
               end
            end
         end

         // shift entries of strictly lower severity down, one per cycle
         spq_pkg::ST_CMP: begin
            if (rd_data_ff.sev < sev_ff) begin
               wr_en   = 1'b1;
               wr_sel  = slot_ff;
               wr_data = rd_data_ff;
               slot_in = slot_m1;
               if (slot_m1 != '0) begin
                  rd_en  = 1'b1;
                  rd_sel = slot_m2;
               end else begin
                  state_in = spq_pkg::ST_PLACE;
               end
            end else begin
               state_in = spq_pkg::ST_PLACE;
            end
         end

         spq_pkg::ST_PLACE: begin
            if (out_free) begin
               wr_en       = 1'b1;
               wr_sel      = slot_ff;
               wr_data.sev = sev_ff;
               wr_data.age = age_ff;
               count_in    = count_inc;
               out_load    = 1'b1;
               ld_status   = spq_pkg::STATUS_ACCEPTED;
               ld_total    = total_inc_wide[spq_pkg::TOTAL_W-1:0];
               state_in    = spq_pkg::ST_IDLE;
            end
         end

         spq_pkg::ST_LIST: begin
            if (out_free) begin
               out_load    = 1'b1;
               ld_status   = spq_pkg::STATUS_ENTRY;
               ld_position = pos_wide[spq_pkg::POS_W-1:0];
               ld_sev      = rd_data_ff.sev;
               ld_age      = rd_data_ff.age;
               ld_last     = (idx_inc == count_ff);
               if (idx_inc == count_ff) begin
                  state_in = spq_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_inc;
                  rd_en  = 1'b1;
                  rd_sel = idx_inc;
               end
            end
         end

         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      sev_ff  <= sev_in;
      age_ff  <= age_in;
      if (out_load) begin
         rsp_status_ff   <= ld_status;
         rsp_position_ff <= ld_position;
         rsp_sev_ff      <= ld_sev;
         rsp_age_ff      <= ld_age;
         rsp_total_ff    <= ld_total;
         rsp_last_ff     <= ld_last;
      end
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_out_severity = rsp_sev_ff;
   assign rsp_out_age      = rsp_age_ff;
   assign rsp_entry_total  = rsp_total_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

/* hdl/severity_priority_queue.sv */
// top level of the severity priority queue
//
// req channel (valid/ready): kind 0 inserts an entry (severity, age), kind 1
// lists the table. items go into a two-entry queue, so the requester can run
// ahead of the table engine by two items.
// rsp channel (valid/ready): an insert gives one item, status accepted with
// the new total, or status full when DEPTH entries are held (table unchanged).
// a list gives one item per held entry in descending severity, equal
// severities in arrival order, with last set on the final one; an empty
// table gives a single empty item.
// an insert compares upward from the bottom of the table, moving each entry of
// lower severity down one slot, then places the new entry and loads its result;
// a full rejection or an empty list loads its result straight from idle. a list
// gives one item per cycle while the receiver takes them. the entry memory has a
// single read and a single write port; an insert shifts one entry per cycle.
// reset empties the table; memory contents need no clearing.
// a stalled receiver holds the result register; the engine waits and the
// request queue fills, after which req_ready drops.
module severity_priority_queue #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic [spq_pkg::SEV_W-1:0]     req_severity,
   input  logic [spq_pkg::AGE_W-1:0]     req_age,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [spq_pkg::POS_W-1:0]     rsp_position,
   output logic [spq_pkg::SEV_W-1:0]     rsp_out_severity,
   output logic [spq_pkg::AGE_W-1:0]     rsp_out_age,
   output logic [spq_pkg::TOTAL_W-1:0]   rsp_entry_total,
   output logic                          rsp_last
);

   logic             cmd_valid;
   logic             cmd_pop;
   spq_pkg::cmd_type cmd;

   spq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_severity (req_severity),
      .req_age      (req_age),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   spq_engine #(
      .DEPTH (DEPTH)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_out_severity (rsp_out_severity),
      .rsp_out_age      (rsp_out_age),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_last         (rsp_last)
   );

endmodule

/* hdl/spq_checker.sv */
// port-level checks for the severity priority queue and their binding
module spq_checker #(
   parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_status,
   input logic [spq_pkg::POS_W-1:0]     rsp_position,
   input logic [spq_pkg::SEV_W-1:0]     rsp_out_severity,
   input logic [spq_pkg::AGE_W-1:0]     rsp_out_age,
   input logic [spq_pkg::TOTAL_W-1:0]   rsp_entry_total,
   input logic                          rsp_last
);

   localparam logic [spq_pkg::TOTAL_W-1:0] TOTAL_FULL = spq_pkg::TOTAL_W'(DEPTH);

   // no result straight out of reset
   assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds its status, position, total and last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_position) && $stable(rsp_entry_total) && $stable(rsp_last))
      else $error("stalled result changed");

   // acknowledgements and empty lists are single, final items
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != spq_pkg::STATUS_ENTRY |-> rsp_last
         && rsp_position == '0 && rsp_out_severity == '0 && rsp_out_age == '0)
      else $error("non-entry result malformed");

   // a full rejection reports a full table
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::STATUS_FULL |-> rsp_entry_total == TOTAL_FULL)
      else $error("full rejection with wrong total");

   // an empty list reports no entries
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY |-> rsp_entry_total == '0)
      else $error("empty list with nonzero total");

endmodule

bind severity_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

/* tb/tb_severity_priority_queue.sv */
// self-checking testbench for the severity priority queue
module tb_severity_priority_queue;

   localparam int TABLE_DEPTH = spq_pkg::DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_STALL = 300;

   typedef struct packed {
      spq_pkg::status_type                status;
      logic [spq_pkg::POS_W-1:0]          position;
      logic [spq_pkg::SEV_W-1:0]          sev;
      logic [spq_pkg::AGE_W-1:0]          age;
      logic [spq_pkg::TOTAL_W-1:0]        total;
      logic                               last;
   } answer_type;

   typedef struct packed {
      spq_pkg::op_type                    kind;
      logic [spq_pkg::SEV_W-1:0]          sev;
      logic [spq_pkg::AGE_W-1:0]          age;
      logic                               pinned;
      spq_pkg::status_type                pin_status;
      logic [spq_pkg::TOTAL_W-1:0]        pin_total;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic [spq_pkg::SEV_W-1:0] req_severity = '0;
   logic [spq_pkg::AGE_W-1:0] req_age = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [spq_pkg::POS_W-1:0] rsp_position;
   logic [spq_pkg::SEV_W-1:0] rsp_out_severity;
   logic [spq_pkg::AGE_W-1:0] rsp_out_age;
   logic [spq_pkg::TOTAL_W-1:0] rsp_entry_total;
   logic rsp_last;

   // own copy of the sorted table
   logic [spq_pkg::SEV_W-1:0] ward_sev [TABLE_DEPTH];
   logic [spq_pkg::AGE_W-1:0] ward_age [TABLE_DEPTH];
   int ward_count = 0;

   answer_type owed_answers [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int req_idle_pct = 10;
   int rsp_idle_pct = 56;
   logic long_stall_req = 1'b0;
   logic long_stall_done = 1'b0;
   int stall_left = 0;

   // typed-in results only for the empty list and the first few inserts
   stim_type directed_rows [17] = '{
      '{spq_pkg::OP_LIST,   6'd0,  8'd0,   1'b1, spq_pkg::STATUS_EMPTY,    6'd0},
      '{spq_pkg::OP_INSERT, 6'd1,  8'd0,   1'b1, spq_pkg::STATUS_ACCEPTED, 6'd1},
      '{spq_pkg::OP_INSERT, 6'd50, 8'd150, 1'b1, spq_pkg::STATUS_ACCEPTED, 6'd2},
      '{spq_pkg::OP_INSERT, 6'd0,  8'd255, 1'b1, spq_pkg::STATUS_ACCEPTED, 6'd3},
      '{spq_pkg::OP_INSERT, 6'd63, 8'd1,   1'b1, spq_pkg::STATUS_ACCEPTED, 6'd4},
      '{spq_pkg::OP_INSERT, 6'd25, 8'd10,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_INSERT, 6'd25, 8'd11,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_INSERT, 6'd25, 8'd12,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_LIST,   6'd63, 8'd255, 1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_INSERT, 6'd50, 8'd20,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_INSERT, 6'd0,  8'd21,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_INSERT, 6'd63, 8'd22,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_INSERT, 6'd1,  8'd23,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_LIST,   6'd0,  8'd0,   1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_INSERT, 6'd42, 8'h55,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_INSERT, 6'd21, 8'hAA,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0},
      '{spq_pkg::OP_LIST,   6'd42, 8'h55,  1'b0, spq_pkg::STATUS_ACCEPTED, 6'd0}
   };

   severity_priority_queue #(
      .DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_severity(req_severity),
      .req_age(req_age),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_position(rsp_position),
      .rsp_out_severity(rsp_out_severity),
      .rsp_out_age(rsp_out_age),
      .rsp_entry_total(rsp_entry_total),
      .rsp_last(rsp_last)
   );

   always #5 clock = ~clock;

   function automatic answer_type make_answer(spq_pkg::status_type status, int pos,
                                              logic [spq_pkg::SEV_W-1:0] sev,
                                              logic [spq_pkg::AGE_W-1:0] age,
                                              logic last);
      answer_type ans;
      ans.status = status;
      ans.position = pos[spq_pkg::POS_W-1:0];
      ans.sev = sev;
      ans.age = age;
      ans.total = ward_count[spq_pkg::TOTAL_W-1:0];
      ans.last = last;
      return ans;
   endfunction

   // updates the table copy and queues the results one item causes
   task automatic triage_step(input spq_pkg::op_type kind,
                              input logic [spq_pkg::SEV_W-1:0] sev,
                              input logic [spq_pkg::AGE_W-1:0] age);
      int slot;
      if (kind == spq_pkg::OP_INSERT) begin
         if (ward_count >= TABLE_DEPTH) begin
            owed_answers.push_back(make_answer(spq_pkg::STATUS_FULL, 0, '0, '0, 1'b1));
         end else begin
            // equal severities stay ahead of the newcomer
            slot = ward_count;
            while (slot > 0 && ward_sev[slot-1] < sev) begin
               ward_sev[slot] = ward_sev[slot-1];
               ward_age[slot] = ward_age[slot-1];
               slot--;
            end
            ward_sev[slot] = sev;
            ward_age[slot] = age;
            ward_count++;
            owed_answers.push_back(make_answer(spq_pkg::STATUS_ACCEPTED, 0, '0, '0, 1'b1));
         end
      end else if (ward_count == 0) begin
         owed_answers.push_back(make_answer(spq_pkg::STATUS_EMPTY, 0, '0, '0, 1'b1));
      end else begin
         for (int i = 0; i < ward_count; i++) begin
            owed_answers.push_back(make_answer(spq_pkg::STATUS_ENTRY, i, ward_sev[i],
                                               ward_age[i], i + 1 == ward_count));
         end
      end
   endtask

   // called at a clock edge; returns at the edge where the item is taken
   task automatic offer_item(input spq_pkg::op_type kind,
                             input logic [spq_pkg::SEV_W-1:0] sev,
                             input logic [spq_pkg::AGE_W-1:0] age);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_severity <= sev;
      req_age <= age;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      triage_step(kind, sev, age);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      while (owed_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [spq_pkg::SEV_W-1:0] pick_severity();
      case ($urandom_range(3))
         0: return spq_pkg::SEV_W'($urandom_range(63));
         1: return spq_pkg::SEV_W'(25 * $urandom_range(2));
         default: return spq_pkg::SEV_W'($urandom_range(50, 1));
      endcase
   endfunction

   task automatic random_items(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 30) begin
            offer_item(spq_pkg::OP_LIST, spq_pkg::SEV_W'($urandom_range(63)),
                       spq_pkg::AGE_W'($urandom_range(255)));
         end else begin
            offer_item(spq_pkg::OP_INSERT, pick_severity(),
                       spq_pkg::AGE_W'($urandom_range(255)));
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 50) begin
         $display("mismatch in %s: got %0d, want %0d, cycle %0d", what, got, want,
                  cycle_count);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", owed_answers.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (long_stall_req && !long_stall_done) begin
         long_stall_done <= 1'b1;
         stall_left <= LONG_STALL;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_answers.size() == 0) begin
            report_mismatch("unowed result, status", 32'(rsp_status), 0);
         end else begin
            want = owed_answers.pop_front();
            check_field("status", 32'(rsp_status), 32'(want.status));
            check_field("position", 32'(rsp_position), 32'(want.position));
            check_field("out_severity", 32'(rsp_out_severity), 32'(want.sev));
            check_field("out_age", 32'(rsp_out_age), 32'(want.age));
            check_field("entry_total", 32'(rsp_entry_total), 32'(want.total));
            check_field("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   initial begin
      answer_type pin;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         offer_item(directed_rows[r].kind, directed_rows[r].sev, directed_rows[r].age);
         if (directed_rows[r].pinned) begin
            void'(owed_answers.pop_back());
            pin.status = directed_rows[r].pin_status;
            pin.position = '0;
            pin.sev = '0;
            pin.age = '0;
            pin.total = directed_rows[r].pin_total;
            pin.last = 1'b1;
            owed_answers.push_back(pin);
         end
      end

      random_items(84);
      drain_answers();
      req_idle_pct <= 56;
      rsp_idle_pct <= 10;
      random_items(83);
      drain_answers();
      req_idle_pct <= 0;
      rsp_idle_pct <= 0;
      long_stall_req <= 1'b1;
      random_items(83);
      drain_answers();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
